// ===== rtl/dte_pkg.sv =====
// Package for the domain trie engine: sizes, codes, payload and control types.
package dte_pkg;

    localparam int NodeCount    = 1024;
    localparam int AlphabetSize = 38;
    localparam int NodeW        = $clog2(NodeCount);
    localparam int EdgeW        = 6;
    localparam int SlotCount    = NodeCount * AlphabetSize;
    localparam int SlotW        = $clog2(SlotCount);
    localparam int CountW       = 6;

    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic        last_char;
        logic [31:0] ip_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  node_index;
        logic [31:0] found_ip;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;    // write clear pass address
        logic load_item;   // latch item, look up child slot
        logic descend;     // apply child lookup result
        logic finish;      // last-character action
        logic walk_check;  // read node of erase walk
        logic walk_step;   // unlink node and move up
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic walk_stop;
    } t_sts;

    // Edge id of a byte; valid=0 when not allowed
    function automatic logic [EdgeW:0] edge_of(input logic [7:0] c);
        logic [7:0] l;
        l = c;
        if (c >= 8'h41 && c <= 8'h5A) l = c + 8'h20;
        if (l >= 8'h61 && l <= 8'h7A) return {1'b1, 6'(l - 8'h61)};
        if (l >= 8'h30 && l <= 8'h39) return {1'b1, 6'(l - 8'h30 + 8'd26)};
        if (l == 8'h2D) return {1'b1, 6'd36};
        if (l == 8'h2E) return {1'b1, 6'd37};
        return '0;
    endfunction

endpackage

// ===== rtl/dte_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module dte_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/dte_datapath.sv =====
// Datapath: trie tables, walk registers and result register.
module dte_datapath import dte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_sts      o_sts,
    output t_out_item o_result
);
    logic [SlotW-1:0]  r_clr_addr;
    logic [NodeW-1:0]  r_cur, r_used, r_walk;
    logic              r_aborted;
    logic [1:0]        r_code;
    t_in_item          r_item;
    logic [EdgeW:0]    r_edge;
    logic [SlotW-1:0]  r_slot;
    logic              r_dec;
    t_out_item         r_res;
    t_out_item         n_res;

    logic              cl_we, pl_we, ie_we, ip_we, cnt_we, end_we;
    logic [SlotW-1:0]  cl_waddr, cl_raddr;
    logic [NodeW-1:0]  cl_wdata, cl_rdata, pl_waddr, pl_wdata, pl_rdata;
    logic [NodeW-1:0]  ie_waddr, pl_raddr;
    logic [EdgeW-1:0]  ie_wdata, ie_rdata;
    logic [NodeW-1:0]  ip_waddr;
    logic [31:0]       ip_rdata;
    logic [NodeW-1:0]  nd_raddr, cnt_waddr, end_waddr;
    logic [CountW-1:0] cnt_wdata, cnt_rdata, eff_cnt;
    logic              end_wdata, end_rdata;
    logic              erase_ok;
    logic [EdgeW:0]    in_edge;
    logic              full;

    assign in_edge  = edge_of(i_item.char_code);
    assign cl_raddr = SlotW'(r_cur) * SlotW'(AlphabetSize) + SlotW'(in_edge[EdgeW-1:0]);
    assign full     = (r_used >= NodeW'(NodeCount - 1));
    assign pl_raddr = i_cmd.walk_step ? pl_rdata : r_walk;
    assign nd_raddr = i_cmd.walk_check ? r_walk : r_cur;

    dte_ram #(.Width(NodeW), .Depth(SlotCount)) u_child (
        .i_clk, .i_we(cl_we), .i_waddr(cl_waddr), .i_wdata(cl_wdata),
        .i_raddr(cl_raddr), .o_rdata(cl_rdata));
    dte_ram #(.Width(NodeW), .Depth(NodeCount)) u_parent (
        .i_clk, .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_raddr(pl_raddr), .o_rdata(pl_rdata));
    dte_ram #(.Width(EdgeW), .Depth(NodeCount)) u_inedge (
        .i_clk, .i_we(ie_we), .i_waddr(ie_waddr), .i_wdata(ie_wdata),
        .i_raddr(pl_raddr), .o_rdata(ie_rdata));
    dte_ram #(.Width(32), .Depth(NodeCount)) u_ip (
        .i_clk, .i_we(ip_we), .i_waddr(ip_waddr), .i_wdata(r_item.ip_address),
        .i_raddr(r_cur), .o_rdata(ip_rdata));
    dte_ram #(.Width(CountW), .Depth(NodeCount)) u_count (
        .i_clk, .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(nd_raddr), .o_rdata(cnt_rdata));
    dte_ram #(.Width(1), .Depth(NodeCount)) u_end (
        .i_clk, .i_we(end_we), .i_waddr(end_waddr), .i_wdata(end_wdata),
        .i_raddr(nd_raddr), .o_rdata(end_rdata));

    // descend: slot missing and insert allocates
    logic alloc;
    assign alloc = i_cmd.descend && !r_aborted && r_edge[EdgeW] && cl_rdata == '0
                   && r_item.opcode == OP_INSERT && !full;
    logic [NodeW-1:0] up;
    assign up = pl_rdata;

    // the parent's child count is lowered one step late, when the walk reaches it
    assign eff_cnt  = (r_dec && cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;
    assign erase_ok = !r_aborted && r_item.opcode == OP_ERASE && end_rdata;

    always_comb begin
        cl_we = 1'b0; cl_waddr = r_slot; cl_wdata = '0;
        pl_we = 1'b0; pl_waddr = '0; pl_wdata = '0;
        ie_we = 1'b0; ie_waddr = r_used + 1'b1; ie_wdata = r_edge[EdgeW-1:0];
        ip_we = 1'b0; ip_waddr = r_cur;
        cnt_we = 1'b0; cnt_waddr = r_cur; cnt_wdata = cnt_rdata + 1'b1;
        end_we = 1'b0; end_waddr = r_cur; end_wdata = 1'b0;
        if (i_cmd.clr_step) begin
            cl_we = 1'b1; cl_waddr = r_clr_addr;
            pl_we = 1'b1; pl_waddr = r_clr_addr[NodeW-1:0];
            cnt_we = 1'b1; cnt_waddr = r_clr_addr[NodeW-1:0]; cnt_wdata = '0;
            end_we = 1'b1; end_waddr = r_clr_addr[NodeW-1:0];
        end
        if (alloc) begin
            cl_we = 1'b1; cl_wdata = r_used + 1'b1;
            pl_we = 1'b1; pl_waddr = r_used + 1'b1; pl_wdata = r_cur;
            ie_we = 1'b1;
            cnt_we = 1'b1; cnt_waddr = r_cur; cnt_wdata = cnt_rdata + 1'b1;
        end
        if (i_cmd.finish && !r_aborted && r_item.opcode == OP_INSERT) begin
            ip_we = 1'b1;
            end_we = 1'b1; end_waddr = r_cur; end_wdata = 1'b1;
        end
        if (i_cmd.finish && erase_ok) begin
            end_we = 1'b1; end_waddr = r_cur; end_wdata = 1'b0;
        end
        if (i_cmd.walk_step && r_dec) begin
            cnt_we = 1'b1; cnt_waddr = r_walk; cnt_wdata = eff_cnt;
        end
        if (i_cmd.walk_step && !o_sts.walk_stop) begin
            cl_we = 1'b1;
            cl_waddr = SlotW'(up) * SlotW'(AlphabetSize) + SlotW'(ie_rdata);
            pl_we = 1'b1; pl_waddr = r_walk;
        end
    end

    always_comb begin
        n_res = '0;
        if (r_aborted) n_res.status = r_code;
        else if (r_item.opcode == OP_INSERT) n_res.node_index = r_cur;
        else if (!end_rdata) n_res.status = ST_MISS;
        else if (r_item.opcode == OP_ERASE) n_res.node_index = r_cur;
        else begin
            n_res.node_index = r_cur; n_res.found_ip = ip_rdata;
        end
    end

    // walk stop test uses node r_walk with its tables now on the read ports
    assign o_sts.walk_stop = (r_walk == '0) || (eff_cnt != '0) || end_rdata
                             || ie_rdata >= EdgeW'(AlphabetSize);
    assign o_sts.clr_done  = (r_clr_addr == SlotW'(SlotCount - 1));
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0; r_cur <= '0; r_used <= '0; r_aborted <= 1'b0;
            r_code <= ST_OK; r_walk <= '0; r_dec <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.load_item) begin
                r_item <= i_item;
                r_edge <= in_edge;
                r_slot <= cl_raddr;
            end
            if (i_cmd.descend && !r_aborted) begin
                if (!r_edge[EdgeW]) begin
                    r_aborted <= 1'b1; r_code <= ST_BAD;
                end else if (cl_rdata == '0) begin
                    if (r_item.opcode != OP_INSERT) begin
                        r_aborted <= 1'b1; r_code <= ST_MISS;
                    end else if (full) begin
                        r_aborted <= 1'b1; r_code <= ST_FULL;
                    end else begin
                        r_used <= r_used + 1'b1;
                        r_cur <= r_used + 1'b1;
                    end
                end else begin
                    r_cur <= cl_rdata;
                end
            end
            if (i_cmd.finish) begin
                r_res <= n_res;
                // only a successful erase walks; node 0 stops at once
                r_walk <= erase_ok ? r_cur : '0;
                r_dec <= 1'b0;
                r_cur <= '0; r_aborted <= 1'b0; r_code <= ST_OK;
            end
            if (i_cmd.walk_step) begin
                r_dec <= !o_sts.walk_stop;
                if (!o_sts.walk_stop) r_walk <= up;
            end
        end
    end
endmodule

// ===== rtl/dte_ctrl.sv =====
// Controller: clear pass, per-character sequencing, erase walk, output handshake.
module dte_ctrl import dte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last,
    input  logic i_erase,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_DESC, S_LOOK, S_FIN, S_WCHK, S_WSTEP
    } t_state;
    t_state r_state;
    logic   r_valid, r_last, r_erase;

    assign o_valid = r_valid;
    assign o_ready = (r_state == S_IDLE) && !r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.clr_step   = (r_state == S_CLR);
        o_cmd.load_item  = i_valid && o_ready;
        o_cmd.descend    = (r_state == S_DESC);
        o_cmd.finish     = (r_state == S_FIN);
        o_cmd.walk_check = (r_state == S_WCHK);
        o_cmd.walk_step  = (r_state == S_WSTEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_valid <= 1'b0; r_last <= 1'b0; r_erase <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_CLR:  if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE: if (i_valid && o_ready) begin
                    r_state <= S_DESC; r_last <= i_last; r_erase <= i_erase;
                end
                S_DESC: r_state <= r_last ? S_LOOK : S_IDLE;
                // node tables read at the final node
                S_LOOK: r_state <= S_FIN;
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= r_erase ? S_WCHK : S_IDLE;
                end
                S_WCHK:  r_state <= S_WSTEP;
                S_WSTEP: r_state <= i_sts.walk_stop ? S_IDLE : S_WCHK;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/domain_trie_engine_unit.sv =====
// Domain trie engine top level.
// Each character passes the idle (accept) and descend states; the last character then passes
// the look and finish states, where its result is registered. A new character is taken only
// after the child-table read then write of the last; the next item waits until a result is
// taken, and an erase adds a check and a step state per walk node visited. Reset: a clearing
// pass over all child slots sweeps the child, parent, count and end tables before the first item is accepted.
module domain_trie_engine_unit import dte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    t_cmd cmd;
    t_sts sts;

    dte_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_last(i_data.last_char),
        .i_erase(i_data.opcode == OP_ERASE), .o_ready, .o_valid, .i_ready,
        .i_sts(sts), .o_cmd(cmd));

    dte_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_item(i_data), .o_sts(sts), .o_result(o_data));
endmodule

// ===== rtl/dte_checker.sv =====
// Port-level assertions for the domain trie engine, bound to the top level.
module dte_checker import dte_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_ok_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.node_index == '0 && o_data.found_ip == '0)
        else $error("nonzero fields on failure");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("back-to-back accept");
endmodule

bind domain_trie_engine_unit dte_checker u_chk (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the domain trie engine: name search, insert and erase.
module tb;
    import dte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // unused opcode, behaves as search
    localparam logic [1:0] OpSpare = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    domain_trie_engine_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow trie
    logic [NodeW-1:0]  kid_tab [SlotCount];
    logic [NodeW-1:0]  up_tab [NodeCount];
    logic [EdgeW-1:0]  via_tab [NodeCount];
    logic [CountW-1:0] nkid_tab [NodeCount];
    logic              term_tab [NodeCount];
    logic [31:0]       addr_tab [NodeCount];
    int unsigned       alloc_cnt;
    logic [NodeW-1:0]  walk_node;
    bit                name_dead;
    logic [1:0]        dead_status;

    t_out_item   lookup_q[$];
    int          errors = 0;
    int          chars_sent = 0;
    int          results_seen = 0;
    int          full_seen = 0;
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;
    bit          rx_hold_req = 1'b0;
    string       name_pool[$];

    function automatic int char_edge(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a";
        if (c >= "0" && c <= "9") return c - "0" + 26;
        if (c == "-") return 36;
        if (c == ".") return 37;
        return -1;
    endfunction

    function automatic void trie_clear();
        foreach (kid_tab[i]) kid_tab[i] = '0;
        foreach (up_tab[i]) begin
            up_tab[i] = '0;
            via_tab[i] = '0;
            nkid_tab[i] = '0;
            term_tab[i] = 1'b0;
            addr_tab[i] = '0;
        end
        alloc_cnt = 0;
        walk_node = '0;
        name_dead = 1'b0;
        dead_status = ST_OK;
    endfunction

    function automatic void unlink_upward(input logic [NodeW-1:0] start);
        logic [NodeW-1:0] n;
        logic [NodeW-1:0] parent;
        n = start;
        while (n != 0) begin
            if (nkid_tab[n] != 0 || term_tab[n]) break;
            parent = up_tab[n];
            kid_tab[parent * AlphabetSize + via_tab[n]] = '0;
            if (nkid_tab[parent] != 0) nkid_tab[parent]--;
            up_tab[n] = '0;
            n = parent;
        end
    endfunction

    // Advance the shadow trie by one character; returns 1 when a result is due
    function automatic bit trie_step(input t_in_item it, output t_out_item r);
        int id;
        int slot;
        logic [NodeW-1:0] nxt;
        r = '0;
        if (!name_dead) begin
            id = char_edge(it.char_code);
            if (id < 0) begin
                name_dead = 1'b1;
                dead_status = ST_BAD;
            end else begin
                slot = walk_node * AlphabetSize + id;
                nxt = kid_tab[slot];
                if (nxt != 0) begin
                    walk_node = nxt;
                end else if (it.opcode == OP_INSERT) begin
                    if (alloc_cnt >= NodeCount - 1) begin
                        name_dead = 1'b1;
                        dead_status = ST_FULL;
                    end else begin
                        alloc_cnt++;
                        nxt = NodeW'(alloc_cnt);
                        kid_tab[slot] = nxt;
                        nkid_tab[walk_node]++;
                        up_tab[nxt] = walk_node;
                        via_tab[nxt] = EdgeW'(id);
                        walk_node = nxt;
                    end
                end else begin
                    name_dead = 1'b1;
                    dead_status = ST_MISS;
                end
            end
        end
        if (!it.last_char) return 1'b0;
        if (name_dead) begin
            r.status = dead_status;
        end else if (it.opcode == OP_INSERT) begin
            term_tab[walk_node] = 1'b1;
            addr_tab[walk_node] = it.ip_address;
            r.node_index = walk_node;
        end else if (!term_tab[walk_node]) begin
            r.status = ST_MISS;
        end else if (it.opcode == OP_ERASE) begin
            r.node_index = walk_node;
            term_tab[walk_node] = 1'b0;
            unlink_upward(walk_node);
        end else begin
            r.node_index = walk_node;
            r.found_ip = addr_tab[walk_node];
        end
        walk_node = '0;
        name_dead = 1'b0;
        dead_status = ST_OK;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [1:0] op, input logic [7:0] ch, input bit last,
                             input logic [31:0] ip);
        t_in_item  it;
        t_out_item r;
        int        gap;
        it.opcode = op;
        it.char_code = ch;
        it.last_char = last;
        it.ip_address = ip;
        gap = tx_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        chars_sent++;
        if (trie_step(it, r)) lookup_q.push_back(r);
    endtask

    task automatic send_name(input logic [1:0] op, input string s, input logic [31:0] ip);
        for (int i = 0; i < s.len(); i++)
            send_char(op, s[i], i == s.len() - 1, ip);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_name(OP_INSERT, "a", 32'hFFFF_FFFF);
        send_name(OP_SEARCH, "A", 32'h0);
        send_name(OP_INSERT, "Zz09-.", 32'h0);
        send_name(OP_SEARCH, "zZ09-.", 32'h1234_5678);
        send_name(OP_SEARCH, "zz", 32'h0);          // prefix, not a name end
        send_name(OP_SEARCH, "q", 32'h0);           // missing edge
        send_name(OP_INSERT, "b_c", 32'h5);         // invalid aborts insert
        send_name(OP_SEARCH, "x\x80", 32'h0);       // miss wins over later invalid
        send_name(OpSpare, "a", 32'h0);             // opcode 3 acts as search
        send_char(OP_INSERT, "a", 1'b0, 32'h0);     // mixed opcodes in one name
        send_char(OP_SEARCH, "b", 1'b1, 32'h0);
        send_name(OP_INSERT, "ab", 32'hA5A5_5A5A);
        send_name(OP_ERASE, "ab", 32'h0);           // walk stops at another name end
        send_name(OP_SEARCH, "a", 32'h0);
        send_name(OP_ERASE, "a", 32'h0);
        send_name(OP_SEARCH, "a", 32'h0);
        send_name(OP_ERASE, "nope", 32'h0);
    endtask

    // Receiver blocks for a long stretch while the sender offers names with no gaps
    task automatic test_backpressure();
        tx_fast = 1'b1;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 8; i++) send_name(OP_INSERT, name_pool[i], $urandom);
        for (int i = 0; i < 8; i++) send_name(OP_SEARCH, name_pool[i], $urandom);
        tx_fast = 1'b0;
        wait_idle();
    endtask

    task automatic test_random(input int n_chars);
        int start;
        int k;
        int r;
        string s;
        logic [1:0] op;
        logic [31:0] ip;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            if ($urandom_range(0, 99) < 8) begin
                tx_fast = !tx_fast;
                rx_fast = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            ip = $urandom;
            if (r < 12) begin
                send_char(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 3) == 0, ip);
            end else begin
                s = name_pool[$urandom_range(0, name_pool.size() - 1)];
                op = (r < 45) ? OP_INSERT : (r < 75) ? OP_SEARCH :
                     (r < 97) ? OP_ERASE : OpSpare;
                k = $urandom_range(0, 9);
                for (int i = 0; i < s.len(); i++) begin
                    if (k == 0 && i == s.len() / 2)
                        send_char(op, 8'($urandom_range(0, 255)), i == s.len() - 1, ip);
                    else if (k == 1)
                        send_char(op, (s[i] >= "a" && s[i] <= "z") ? s[i] - 8'h20 : s[i],
                                  i == s.len() - 1, ip);
                    else
                        send_char(op, s[i], i == s.len() - 1, ip);
                end
            end
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    // Long fresh names until the node store runs out
    task automatic test_table_full();
        string alpha;
        int    len;
        alpha = "abcdefghijklmnopqrstuvwxyz0123456789-.";
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        while (alloc_cnt < NodeCount - 1) begin
            len = $urandom_range(60, 80);
            send_char(OP_INSERT, "q", 1'b0, 32'h0);
            for (int i = 1; i < len; i++)
                send_char(OP_INSERT, alpha[$urandom_range(0, 37)], i == len - 1, $urandom);
            wait_idle();
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        send_name(OP_INSERT, "full-x", 32'h1);
        send_name(OP_INSERT, "full-y", 32'h2);
        send_name(OP_SEARCH, name_pool[0], 32'h0);
        wait_idle();
    endtask

    // Receiver
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                n = rx_fast ? 0 : $urandom_range(0, 14);
                if (n > 0) begin
                    i_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Result check
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (lookup_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $realtime, o_data);
            end else begin
                w = lookup_q.pop_front();
                if (w.status == ST_FULL) full_seen++;
                if (o_data.status !== w.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, w.status, o_data.status);
                end
                if (o_data.node_index !== w.node_index) begin
                    errors++;
                    $display("%0t: node_index expected %0d actual %0d",
                             $realtime, w.node_index, o_data.node_index);
                end
                if (o_data.found_ip !== w.found_ip) begin
                    errors++;
                    $display("%0t: found_ip expected %h actual %h",
                             $realtime, w.found_ip, o_data.found_ip);
                end
            end
        end
    end

    // Watchdog: idle limit covers the clearing pass after reset
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > 150000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        string s;
        string alpha;
        int    idx;
        alpha = "abc09-.";
        for (int i = 0; i < 24; i++) begin
            s = "";
            for (int j = 0; j < $urandom_range(1, 5); j++) begin
                idx = $urandom_range(0, 6);
                s = {s, alpha.substr(idx, idx)};
            end
            name_pool.push_back(s);
        end
        trie_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_idle();
        test_backpressure();
        test_random(780);
        wait_idle();
        test_table_full();
        $display("Sent %0d characters, checked %0d results (%0d table-full).",
                 chars_sent, results_seen, full_seen);
        $display("Covered directed names, back-pressure, random name traffic and node exhaustion.");
        if (errors == 0 && lookup_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
